/* src/ecpu_pkg.sv */
// shared types, constants and opcode decode tables for the processor core
package ecpu_pkg;

   localparam int MEM_BYTES = 65536;
   localparam int ADDR_W    = $clog2(MEM_BYTES);

   // status bit positions
   localparam int P_C = 0;
   localparam int P_Z = 1;
   localparam int P_I = 2;
   localparam int P_D = 3;
   localparam int P_B = 4;
   localparam int P_5 = 5;
   localparam int P_V = 6;
   localparam int P_N = 7;

   localparam logic [7:0]  STACK_PAGE = 8'h01;
   localparam logic [7:0]  P_RESET    = 8'h20;
   localparam logic [7:0]  SP_RESET   = 8'hFF;
   localparam logic [15:0] VEC_LO     = 16'hFFFE;
   localparam logic [15:0] VEC_HI     = 16'hFFFF;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_EXEC  = 2'd2;
   localparam logic [1:0] ACT_SETPC = 2'd3;

   typedef enum logic [3:0] {
      M_NONE, M_IMP, M_ACC, M_IMM, M_ZPG, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY,
      M_IND, M_XIN, M_YIN, M_REL
   } mode_type;

   typedef enum logic [5:0] {
      K_BAD, K_ADC, K_AND, K_ASL, K_BCC, K_BCS, K_BEQ, K_BIT, K_BMI, K_BNE, K_BPL,
      K_BRK, K_BVC, K_BVS, K_CLC, K_CLD, K_CLI, K_CLV, K_CMP, K_CPX, K_CPY, K_DEC,
      K_DEX, K_DEY, K_EOR, K_INC, K_INX, K_INY, K_JMP, K_JSR, K_LDA, K_LDX, K_LDY,
      K_LSR, K_NOP, K_ORA, K_PHA, K_PHP, K_PLA, K_PLP, K_ROL, K_ROR, K_RTI, K_RTS,
      K_SBC, K_SEC, K_SED, K_SEI, K_STA, K_STX, K_STY, K_TAX, K_TAY, K_TSX, K_TXA,
      K_TXS, K_TYA
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_READ, ST_OP, ST_OPR1, ST_OPR2, ST_PTR1, ST_PTR2, ST_EXEC,
      ST_PULL1, ST_PULL2, ST_PULL3, ST_JLO, ST_PUSH_LO, ST_PUSH_P, ST_JHI,
      ST_VEC0, ST_VEC1, ST_VEC2
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] address;
      logic [7:0]  data;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [7:0]  accumulator;
      logic [7:0]  index_x;
      logic [7:0]  index_y;
      logic [7:0]  stack_pointer;
      logic [7:0]  status_flags;
      logic [15:0] program_counter;
      logic        bad_opcode;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  a;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  sp;
      logic [7:0]  p;
      logic [15:0] pc;
   } regs_type;

   typedef struct packed {
      kind_type    kind;
      mode_type    mode;
      regs_type    regs;
      logic [7:0]  val;
      logic [15:0] ea;
   } alu_in_type;

   typedef struct packed {
      regs_type   regs;
      logic [7:0] wdata;
   } alu_out_type;

   localparam kind_type KIND_TABLE [256] = '{
      K_BRK,K_ORA,K_BAD,K_BAD,K_BAD,K_ORA,K_ASL,K_BAD,
      K_PHP,K_ORA,K_ASL,K_BAD,K_BAD,K_ORA,K_ASL,K_BAD,
      K_BPL,K_ORA,K_BAD,K_BAD,K_BAD,K_ORA,K_ASL,K_BAD,
      K_CLC,K_ORA,K_BAD,K_BAD,K_BAD,K_ORA,K_ASL,K_BAD,
      K_JSR,K_AND,K_BAD,K_BAD,K_BIT,K_AND,K_ROL,K_BAD,
      K_PLP,K_AND,K_ROL,K_BAD,K_BIT,K_AND,K_ROL,K_BAD,
      K_BMI,K_AND,K_BAD,K_BAD,K_BAD,K_AND,K_ROL,K_BAD,
      K_SEC,K_AND,K_BAD,K_BAD,K_BAD,K_AND,K_ROL,K_BAD,
      K_RTI,K_EOR,K_BAD,K_BAD,K_BAD,K_EOR,K_LSR,K_BAD,
      K_PHA,K_EOR,K_LSR,K_BAD,K_JMP,K_EOR,K_LSR,K_BAD,
      K_BVC,K_EOR,K_BAD,K_BAD,K_BAD,K_EOR,K_LSR,K_BAD,
      K_CLI,K_EOR,K_BAD,K_BAD,K_BAD,K_EOR,K_LSR,K_BAD,
      K_RTS,K_ADC,K_BAD,K_BAD,K_BAD,K_ADC,K_ROR,K_BAD,
      K_PLA,K_ADC,K_ROR,K_BAD,K_JMP,K_ADC,K_ROR,K_BAD,
      K_BVS,K_ADC,K_BAD,K_BAD,K_BAD,K_ADC,K_ROR,K_BAD,
      K_SEI,K_ADC,K_BAD,K_BAD,K_BAD,K_ADC,K_ROR,K_BAD,
      K_BAD,K_STA,K_BAD,K_BAD,K_STY,K_STA,K_STX,K_BAD,
      K_DEY,K_BAD,K_TXA,K_BAD,K_STY,K_STA,K_STX,K_BAD,
      K_BCC,K_STA,K_BAD,K_BAD,K_STY,K_STA,K_STX,K_BAD,
      K_TYA,K_STA,K_TXS,K_BAD,K_BAD,K_STA,K_BAD,K_BAD,
      K_LDY,K_LDA,K_LDX,K_BAD,K_LDY,K_LDA,K_LDX,K_BAD,
      K_TAY,K_LDA,K_TAX,K_BAD,K_LDY,K_LDA,K_LDX,K_BAD,
      K_BCS,K_LDA,K_BAD,K_BAD,K_LDY,K_LDA,K_LDX,K_BAD,
      K_CLV,K_LDA,K_TSX,K_BAD,K_LDY,K_LDA,K_LDX,K_BAD,
      K_CPY,K_CMP,K_BAD,K_BAD,K_CPY,K_CMP,K_DEC,K_BAD,
      K_INY,K_CMP,K_DEX,K_BAD,K_CPY,K_CMP,K_DEC,K_BAD,
      K_BNE,K_CMP,K_BAD,K_BAD,K_BAD,K_CMP,K_DEC,K_BAD,
      K_CLD,K_CMP,K_BAD,K_BAD,K_BAD,K_CMP,K_DEC,K_BAD,
      K_CPX,K_SBC,K_BAD,K_BAD,K_CPX,K_SBC,K_INC,K_BAD,
      K_INX,K_SBC,K_NOP,K_BAD,K_CPX,K_SBC,K_INC,K_BAD,
      K_BEQ,K_SBC,K_BAD,K_BAD,K_BAD,K_SBC,K_INC,K_BAD,
      K_SED,K_SBC,K_BAD,K_BAD,K_BAD,K_SBC,K_INC,K_BAD
   };

   function automatic mode_type mode_of(input logic [7:0] opc, input kind_type kind);
      mode_type m;
      if (opc[4] == 1'b0) begin
         case (opc[3:0])
            4'h0, 4'h2, 4'h9: m = M_IMM;
            4'h1:             m = M_XIN;
            4'h4, 4'h5, 4'h6: m = M_ZPG;
            4'h8:             m = M_IMP;
            4'hA:             m = M_ACC;
            4'hC, 4'hD, 4'hE: m = M_ABS;
            default:          m = M_NONE;
         endcase
      end else begin
         case (opc[3:0])
            4'h0:             m = M_REL;
            4'h1:             m = M_YIN;
            4'h4, 4'h5, 4'h6: m = M_ZPX;
            4'h8, 4'hA:       m = M_IMP;
            4'h9:             m = M_ABY;
            4'hC, 4'hD, 4'hE: m = M_ABX;
            default:          m = M_NONE;
         endcase
      end
      if (kind inside {K_BRK, K_RTI, K_RTS, K_JSR}) begin
         m = M_IMP;
      end else if (opc == 8'h6C) begin
         m = M_IND;
      end else if (opc == 8'h96 || opc == 8'hB6) begin
         m = M_ZPY;
      end else if (opc == 8'hBE) begin
         m = M_ABY;
      end
      return m;
   endfunction

endpackage

/* src/eight_bit_cpu_instruction_executor.sv */
// top level: command sequencer, architectural registers and the byte memory
//
// An 8-bit processor core with its own byte memory. Each item written with
// start (while busy is low) either writes a memory byte, reads one back, loads
// the program counter or executes one instruction at the program counter.
// Exactly one result comes back per item, on rsp_item for the single cycle
// that rsp_valid is high; it cannot be held off, so capture it when it shows.
// Memory writes and program counter loads answer in the cycle after start;
// memory reads pass through a read state first. For an instruction, every
// opcode, operand, pointer, stack and vector byte goes through the one port
// of the memory, one access per cycle, with a registered read. BRK takes the
// longest. Memory contents are not cleared at reset; reading a byte that
// was never written returns garbage.
module eight_bit_cpu_instruction_executor (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ecpu_pkg::req_type req_item,
   output logic              rsp_valid,
   output ecpu_pkg::rsp_type rsp_item
);

   // architectural registers and sequencer state
   ecpu_pkg::state_type state_ff, state_in;
   ecpu_pkg::regs_type  regs_ff, regs_in;
   ecpu_pkg::kind_type  kind_ff, kind_in;
   ecpu_pkg::mode_type  mode_ff, mode_in;
   logic [15:0]         ea_ff, ea_in;        // effective address or pointer
   logic [7:0]          lo_ff, lo_in;        // low byte waiting for its high half
   logic                done_ff, done_in;
   logic [7:0]          rdat_ff, rdat_in;
   logic                bad_ff, bad_in;

   // memory port
   logic [15:0] mem_addr;
   logic        mem_we;
   logic [7:0]  mem_wdata;
   logic [7:0]  mem_rdata;

   ecpu_pkg::alu_in_type  alu_in;
   ecpu_pkg::alu_out_type alu_out;

   ecpu_pkg::kind_type op_kind;
   ecpu_pkg::mode_type op_mode;
   logic               accept;
   logic [15:0]        pc_inc;
   logic [7:0]         sp_inc, sp_dec;
   logic [15:0]        base;
   logic               mem_write_kind;

   ecpu_ram #(
      .WIDTH (8),
      .DEPTH (ecpu_pkg::MEM_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr[ecpu_pkg::ADDR_W-1:0]),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   ecpu_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   assign accept = start && !busy;
   assign busy   = (state_ff != ecpu_pkg::ST_IDLE);

   // decode straight off the memory read data in the opcode state
   assign op_kind = ecpu_pkg::KIND_TABLE[mem_rdata];
   assign op_mode = ecpu_pkg::mode_of(mem_rdata, op_kind);

   assign pc_inc = regs_ff.pc + 16'd1;
   assign sp_inc = regs_ff.sp + 8'd1;
   assign sp_dec = regs_ff.sp - 8'd1;
   assign base   = {mem_rdata, lo_ff};

   // implied and accumulator modes operate on a instead of a memory byte
   always_comb begin
      alu_in.kind = kind_ff;
      alu_in.mode = mode_ff;
      alu_in.regs = regs_ff;
      alu_in.ea   = ea_ff;
      alu_in.val  = (mode_ff == ecpu_pkg::M_IMP || mode_ff == ecpu_pkg::M_ACC) ?
                    regs_ff.a : mem_rdata;
   end

   assign mem_write_kind =
      (kind_ff inside {ecpu_pkg::K_STA, ecpu_pkg::K_STX, ecpu_pkg::K_STY,
                       ecpu_pkg::K_INC, ecpu_pkg::K_DEC}) ||
      ((kind_ff inside {ecpu_pkg::K_ASL, ecpu_pkg::K_LSR, ecpu_pkg::K_ROL,
                        ecpu_pkg::K_ROR}) && mode_ff != ecpu_pkg::M_ACC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ecpu_pkg::ST_IDLE;
         regs_ff.a  <= 8'd0;
         regs_ff.x  <= 8'd0;
         regs_ff.y  <= 8'd0;
         regs_ff.sp <= ecpu_pkg::SP_RESET;
         regs_ff.p  <= ecpu_pkg::P_RESET;
         regs_ff.pc <= 16'd0;
         done_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         regs_ff  <= regs_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      mode_ff <= mode_in;
      ea_ff   <= ea_in;
      lo_ff   <= lo_in;
      rdat_ff <= rdat_in;
      bad_ff  <= bad_in;
   end

   always_comb begin
      state_in  = state_ff;
      regs_in   = regs_ff;
      kind_in   = kind_ff;
      mode_in   = mode_ff;
      ea_in     = ea_ff;
      lo_in     = lo_ff;
      done_in   = 1'b0;
      rdat_in   = rdat_ff;
      bad_in    = bad_ff;
      mem_addr  = regs_ff.pc;
      mem_we    = 1'b0;
      mem_wdata = 8'd0;

      case (state_ff)
         ecpu_pkg::ST_IDLE: begin
            if (accept) begin
               rdat_in = 8'd0;
               bad_in  = 1'b0;
               case (req_item.action)
                  ecpu_pkg::ACT_WRITE: begin
                     mem_addr  = req_item.address;
                     mem_we    = 1'b1;
                     mem_wdata = req_item.data;
                     done_in   = 1'b1;
                  end
                  ecpu_pkg::ACT_READ: begin
                     mem_addr = req_item.address;
                     state_in = ecpu_pkg::ST_READ;
                  end
                  ecpu_pkg::ACT_EXEC: begin
                     mem_addr = regs_ff.pc;
                     state_in = ecpu_pkg::ST_OP;
                  end
                  default: begin
                     regs_in.pc = req_item.address;
                     done_in    = 1'b1;
                  end
               endcase
            end
         end

         ecpu_pkg::ST_READ: begin
            rdat_in  = mem_rdata;
            done_in  = 1'b1;
            state_in = ecpu_pkg::ST_IDLE;
         end

         // opcode byte is on the read data
         ecpu_pkg::ST_OP: begin
            kind_in    = op_kind;
            mode_in    = op_mode;
            regs_in.pc = pc_inc;
            mem_addr   = pc_inc;
            if (op_kind == ecpu_pkg::K_BAD) begin
               bad_in   = 1'b1;
               done_in  = 1'b1;
               state_in = ecpu_pkg::ST_IDLE;
            end else if (op_mode inside {ecpu_pkg::M_IMP, ecpu_pkg::M_ACC}) begin
               state_in = ecpu_pkg::ST_EXEC;
            end else if (op_mode inside {ecpu_pkg::M_IMM, ecpu_pkg::M_REL}) begin
               ea_in      = pc_inc;
               regs_in.pc = regs_ff.pc + 16'd2;
               state_in   = ecpu_pkg::ST_EXEC;
            end else begin
               state_in = ecpu_pkg::ST_OPR1;
            end
         end

         // first operand byte
         ecpu_pkg::ST_OPR1: begin
            regs_in.pc = pc_inc;
            case (mode_ff)
               ecpu_pkg::M_ZPG: begin
                  ea_in    = {8'd0, mem_rdata};
                  mem_addr = ea_in;
                  state_in = ecpu_pkg::ST_EXEC;
               end
               ecpu_pkg::M_ZPX: begin
                  ea_in    = {8'd0, mem_rdata + regs_ff.x};
                  mem_addr = ea_in;
                  state_in = ecpu_pkg::ST_EXEC;
               end
               ecpu_pkg::M_ZPY: begin
                  ea_in    = {8'd0, mem_rdata + regs_ff.y};
                  mem_addr = ea_in;
                  state_in = ecpu_pkg::ST_EXEC;
               end
               ecpu_pkg::M_XIN: begin
                  ea_in    = {8'd0, mem_rdata + regs_ff.x};
                  mem_addr = ea_in;
                  state_in = ecpu_pkg::ST_PTR1;
               end
               ecpu_pkg::M_YIN: begin
                  ea_in    = {8'd0, mem_rdata};
                  mem_addr = ea_in;
                  state_in = ecpu_pkg::ST_PTR1;
               end
               default: begin
                  lo_in    = mem_rdata;
                  mem_addr = pc_inc;
                  state_in = ecpu_pkg::ST_OPR2;
               end
            endcase
         end

         // second operand byte of the absolute modes
         ecpu_pkg::ST_OPR2: begin
            regs_in.pc = pc_inc;
            case (mode_ff)
               ecpu_pkg::M_ABX: ea_in = base + {8'd0, regs_ff.x};
               ecpu_pkg::M_ABY: ea_in = base + {8'd0, regs_ff.y};
               default:         ea_in = base;
            endcase
            mem_addr = ea_in;
            state_in = (mode_ff == ecpu_pkg::M_IND) ? ecpu_pkg::ST_PTR1 : ecpu_pkg::ST_EXEC;
         end

         // pointer low byte; the high byte stays within the pointer's page
         ecpu_pkg::ST_PTR1: begin
            lo_in    = mem_rdata;
            mem_addr = {ea_ff[15:8], ea_ff[7:0] + 8'd1};
            state_in = ecpu_pkg::ST_PTR2;
         end

         ecpu_pkg::ST_PTR2: begin
            ea_in    = (mode_ff == ecpu_pkg::M_YIN) ? base + {8'd0, regs_ff.y} : base;
            mem_addr = ea_in;
            state_in = ecpu_pkg::ST_EXEC;
         end

         ecpu_pkg::ST_EXEC: begin
            state_in = ecpu_pkg::ST_IDLE;
            if (kind_ff inside {ecpu_pkg::K_PLA, ecpu_pkg::K_PLP, ecpu_pkg::K_RTS,
                                ecpu_pkg::K_RTI}) begin
               regs_in.sp = sp_inc;
               mem_addr   = {ecpu_pkg::STACK_PAGE, sp_inc};
               state_in   = ecpu_pkg::ST_PULL1;
            end else if (kind_ff == ecpu_pkg::K_BRK) begin
               // return address skips the padding byte
               regs_in.pc = pc_inc;
               regs_in.sp = sp_dec;
               mem_addr   = {ecpu_pkg::STACK_PAGE, regs_ff.sp};
               mem_we     = 1'b1;
               mem_wdata  = pc_inc[15:8];
               state_in   = ecpu_pkg::ST_PUSH_LO;
            end else if (kind_ff == ecpu_pkg::K_JSR) begin
               mem_addr = regs_ff.pc;
               state_in = ecpu_pkg::ST_JLO;
            end else if (kind_ff inside {ecpu_pkg::K_PHA, ecpu_pkg::K_PHP}) begin
               regs_in.sp = sp_dec;
               mem_addr   = {ecpu_pkg::STACK_PAGE, regs_ff.sp};
               mem_we     = 1'b1;
               mem_wdata  = alu_out.wdata;
               done_in    = 1'b1;
            end else begin
               regs_in   = alu_out.regs;
               mem_addr  = ea_ff;
               mem_we    = mem_write_kind;
               mem_wdata = alu_out.wdata;
               done_in   = 1'b1;
            end
         end

         ecpu_pkg::ST_PULL1: begin
            state_in = ecpu_pkg::ST_IDLE;
            case (kind_ff)
               ecpu_pkg::K_PLA: begin
                  regs_in.a = mem_rdata;
                  regs_in.p[ecpu_pkg::P_Z] = (mem_rdata == 8'd0);
                  regs_in.p[ecpu_pkg::P_N] = mem_rdata[7];
                  done_in = 1'b1;
               end
               ecpu_pkg::K_PLP: begin
                  regs_in.p = mem_rdata;
                  regs_in.p[ecpu_pkg::P_B] = 1'b0;
                  regs_in.p[ecpu_pkg::P_5] = 1'b1;
                  done_in = 1'b1;
               end
               ecpu_pkg::K_RTI: begin
                  regs_in.p = mem_rdata;
                  regs_in.p[ecpu_pkg::P_B] = 1'b0;
                  regs_in.p[ecpu_pkg::P_5] = 1'b1;
                  regs_in.sp = sp_inc;
                  mem_addr   = {ecpu_pkg::STACK_PAGE, sp_inc};
                  state_in   = ecpu_pkg::ST_PULL2;
               end
               default: begin
                  lo_in      = mem_rdata;
                  regs_in.sp = sp_inc;
                  mem_addr   = {ecpu_pkg::STACK_PAGE, sp_inc};
                  state_in   = ecpu_pkg::ST_PULL2;
               end
            endcase
         end

         ecpu_pkg::ST_PULL2: begin
            if (kind_ff == ecpu_pkg::K_RTI) begin
               lo_in      = mem_rdata;
               regs_in.sp = sp_inc;
               mem_addr   = {ecpu_pkg::STACK_PAGE, sp_inc};
               state_in   = ecpu_pkg::ST_PULL3;
            end else begin
               // return from subroutine lands one past the pushed address
               regs_in.pc = base + 16'd1;
               done_in    = 1'b1;
               state_in   = ecpu_pkg::ST_IDLE;
            end
         end

         ecpu_pkg::ST_PULL3: begin
            regs_in.pc = base;
            done_in    = 1'b1;
            state_in   = ecpu_pkg::ST_IDLE;
         end

         // subroutine call: target low byte in, push the high return byte
         ecpu_pkg::ST_JLO: begin
            lo_in      = mem_rdata;
            regs_in.pc = pc_inc;
            regs_in.sp = sp_dec;
            mem_addr   = {ecpu_pkg::STACK_PAGE, regs_ff.sp};
            mem_we     = 1'b1;
            mem_wdata  = pc_inc[15:8];
            state_in   = ecpu_pkg::ST_PUSH_LO;
         end

         ecpu_pkg::ST_PUSH_LO: begin
            regs_in.sp = sp_dec;
            mem_addr   = {ecpu_pkg::STACK_PAGE, regs_ff.sp};
            mem_we     = 1'b1;
            mem_wdata  = regs_ff.pc[7:0];
            state_in   = (kind_ff == ecpu_pkg::K_BRK) ? ecpu_pkg::ST_PUSH_P :
                                                        ecpu_pkg::ST_JHI;
         end

         ecpu_pkg::ST_PUSH_P: begin
            regs_in.sp = sp_dec;
            mem_addr   = {ecpu_pkg::STACK_PAGE, regs_ff.sp};
            mem_we     = 1'b1;
            mem_wdata  = regs_ff.p;
            mem_wdata[ecpu_pkg::P_B] = 1'b1;
            regs_in.p[ecpu_pkg::P_B] = 1'b0;
            regs_in.p[ecpu_pkg::P_I] = 1'b1;
            state_in   = ecpu_pkg::ST_VEC0;
         end

         ecpu_pkg::ST_VEC0: begin
            mem_addr = ecpu_pkg::VEC_LO;
            state_in = ecpu_pkg::ST_VEC1;
         end

         ecpu_pkg::ST_VEC1: begin
            lo_in    = mem_rdata;
            mem_addr = ecpu_pkg::VEC_HI;
            state_in = ecpu_pkg::ST_VEC2;
         end

         ecpu_pkg::ST_JHI: begin
            mem_addr = regs_ff.pc;
            state_in = ecpu_pkg::ST_VEC2;
         end

         ecpu_pkg::ST_VEC2: begin
            regs_in.pc = base;
            done_in    = 1'b1;
            state_in   = ecpu_pkg::ST_IDLE;
         end

         default: state_in = ecpu_pkg::ST_IDLE;
      endcase
   end

   // result shows the registers as they stand after the item
   assign rsp_valid = done_ff;
   always_comb begin
      rsp_item.read_data       = rdat_ff;
      rsp_item.accumulator     = regs_ff.a;
      rsp_item.index_x         = regs_ff.x;
      rsp_item.index_y         = regs_ff.y;
      rsp_item.stack_pointer   = regs_ff.sp;
      rsp_item.status_flags    = regs_ff.p;
      rsp_item.program_counter = regs_ff.pc;
      rsp_item.bad_opcode      = bad_ff;
   end

   // a result only appears once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ecpu_pkg::ST_IDLE)
      else $error("result strobe while sequencer busy");

   // bit five stays set and the break bit never lives in the register
   a_status_fixed: assert property (@(posedge clock) disable iff (reset)
      regs_ff.p[ecpu_pkg::P_5] && !regs_ff.p[ecpu_pkg::P_B])
      else $error("status fixed bits corrupted");

   a_write_answers: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.action == ecpu_pkg::ACT_WRITE) |=> rsp_valid)
      else $error("memory write item got no result");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ecpu_pkg::ST_READ |-> !mem_we)
      else $error("memory written during a read item");

   a_brk_vector: assert property (@(posedge clock) disable iff (reset)
      state_ff == ecpu_pkg::ST_PUSH_P |=> state_ff == ecpu_pkg::ST_VEC0)
      else $error("status push not followed by vector fetch");

endmodule

/* src/ecpu_ram.sv */
// generic single-port synchronous ram with registered read
module ecpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/ecpu_alu.sv */
// register and flag update for the execute step of one instruction
module ecpu_alu (
   input  ecpu_pkg::alu_in_type  alu_in,
   output ecpu_pkg::alu_out_type alu_out
);

   logic [7:0] a, v, p;
   logic       c, dec;

   // add with carry, binary and decimal
   logic [8:0] sum9;
   logic [5:0] dlo, dlo2, dhi, dhi2, dhi3;
   logic [7:0] mid, adc_a;
   logic       dcarry;

   // subtract with borrow
   logic [7:0] diff, slo, slo2, shi, shi2, shi3, sbc_a;
   logic       borrow, sbc_c;

   // compare
   logic [7:0] cmp_r, cmp_d;

   logic [7:0] r;

   assign a   = alu_in.regs.a;
   assign v   = alu_in.val;
   assign p   = alu_in.regs.p;
   assign c   = p[ecpu_pkg::P_C];
   assign dec = p[ecpu_pkg::P_D];

   always_comb begin
      sum9 = {1'b0, a} + {1'b0, v} + {8'd0, c};
      dlo  = {2'b0, a[3:0]} + {2'b0, v[3:0]} + {5'd0, c};
      dhi  = {2'b0, a[7:4]} + {2'b0, v[7:4]};
      if (dlo > 6'd9) begin
         dlo2 = dlo + 6'd6;
         dhi2 = dhi + 6'd1;
      end else begin
         dlo2 = dlo;
         dhi2 = dhi;
      end
      mid    = {dhi2[3:0], dlo2[3:0]};
      dcarry = (dhi2 > 6'd9);
      dhi3   = dcarry ? dhi2 + 6'd6 : dhi2;
      adc_a  = dec ? {dhi3[3:0], dlo2[3:0]} : sum9[7:0];
   end

   always_comb begin
      borrow = ~c;
      diff   = a - v - {7'd0, borrow};
      sbc_c  = ({1'b0, v} + {8'd0, borrow}) <= {1'b0, a};
      slo    = {4'd0, a[3:0]} - {4'd0, v[3:0]} - {7'd0, borrow};
      shi    = {4'd0, a[7:4]} - {4'd0, v[7:4]};
      if (slo[4]) begin
         slo2 = slo + 8'd10;
         shi2 = shi - 8'd1;
      end else begin
         slo2 = slo;
         shi2 = shi;
      end
      shi3  = shi2[4] ? shi2 + 8'd10 : shi2;
      sbc_a = dec ? {shi3[3:0], slo2[3:0]} : diff;
   end

   always_comb begin
      case (alu_in.kind)
         ecpu_pkg::K_CPX: cmp_r = alu_in.regs.x;
         ecpu_pkg::K_CPY: cmp_r = alu_in.regs.y;
         default:         cmp_r = a;
      endcase
      cmp_d = cmp_r - v;
   end

   always_comb begin
      alu_out.regs  = alu_in.regs;
      alu_out.wdata = v;
      r             = 8'd0;
      case (alu_in.kind)
         ecpu_pkg::K_ADC: begin
            alu_out.regs.a = adc_a;
            alu_out.regs.p[ecpu_pkg::P_Z] = (sum9[7:0] == 8'd0);
            if (dec) begin
               alu_out.regs.p[ecpu_pkg::P_N] = mid[7];
               alu_out.regs.p[ecpu_pkg::P_V] = ~(a[7] ^ v[7]) & (a[7] ^ mid[7]);
               alu_out.regs.p[ecpu_pkg::P_C] = dcarry;
            end else begin
               alu_out.regs.p[ecpu_pkg::P_N] = sum9[7];
               alu_out.regs.p[ecpu_pkg::P_V] = ~(a[7] ^ v[7]) & (a[7] ^ sum9[7]);
               alu_out.regs.p[ecpu_pkg::P_C] = sum9[8];
            end
         end
         ecpu_pkg::K_SBC: begin
            alu_out.regs.a = sbc_a;
            alu_out.regs.p[ecpu_pkg::P_Z] = (diff == 8'd0);
            alu_out.regs.p[ecpu_pkg::P_N] = diff[7];
            alu_out.regs.p[ecpu_pkg::P_C] = sbc_c;
            alu_out.regs.p[ecpu_pkg::P_V] = (a[7] ^ v[7]) & (a[7] ^ diff[7]);
         end
         ecpu_pkg::K_AND, ecpu_pkg::K_ORA, ecpu_pkg::K_EOR, ecpu_pkg::K_LDA,
         ecpu_pkg::K_TXA, ecpu_pkg::K_TYA: begin
            case (alu_in.kind)
               ecpu_pkg::K_AND: r = a & v;
               ecpu_pkg::K_ORA: r = a | v;
               ecpu_pkg::K_EOR: r = a ^ v;
               ecpu_pkg::K_TXA: r = alu_in.regs.x;
               ecpu_pkg::K_TYA: r = alu_in.regs.y;
               default:         r = v;
            endcase
            alu_out.regs.a = r;
            alu_out.regs.p[ecpu_pkg::P_Z] = (r == 8'd0);
            alu_out.regs.p[ecpu_pkg::P_N] = r[7];
         end
         ecpu_pkg::K_ASL, ecpu_pkg::K_LSR, ecpu_pkg::K_ROL, ecpu_pkg::K_ROR: begin
            case (alu_in.kind)
               ecpu_pkg::K_ASL: r = {v[6:0], 1'b0};
               ecpu_pkg::K_LSR: r = {1'b0, v[7:1]};
               ecpu_pkg::K_ROL: r = {v[6:0], c};
               default:         r = {c, v[7:1]};
            endcase
            alu_out.regs.p[ecpu_pkg::P_Z] = (r == 8'd0);
            alu_out.regs.p[ecpu_pkg::P_N] = r[7];
            alu_out.regs.p[ecpu_pkg::P_C] =
               (alu_in.kind inside {ecpu_pkg::K_ASL, ecpu_pkg::K_ROL}) ? v[7] : v[0];
            if (alu_in.mode == ecpu_pkg::M_ACC) begin
               alu_out.regs.a = r;
            end
            alu_out.wdata = r;
         end
         ecpu_pkg::K_INC, ecpu_pkg::K_DEC: begin
            r = (alu_in.kind == ecpu_pkg::K_INC) ? v + 8'd1 : v - 8'd1;
            alu_out.regs.p[ecpu_pkg::P_Z] = (r == 8'd0);
            alu_out.regs.p[ecpu_pkg::P_N] = r[7];
            alu_out.wdata = r;
         end
         ecpu_pkg::K_INX, ecpu_pkg::K_DEX, ecpu_pkg::K_LDX, ecpu_pkg::K_TAX,
         ecpu_pkg::K_TSX: begin
            case (alu_in.kind)
               ecpu_pkg::K_INX: r = alu_in.regs.x + 8'd1;
               ecpu_pkg::K_DEX: r = alu_in.regs.x - 8'd1;
               ecpu_pkg::K_TAX: r = a;
               ecpu_pkg::K_TSX: r = alu_in.regs.sp;
               default:         r = v;
            endcase
            alu_out.regs.x = r;
            alu_out.regs.p[ecpu_pkg::P_Z] = (r == 8'd0);
            alu_out.regs.p[ecpu_pkg::P_N] = r[7];
         end
         ecpu_pkg::K_INY, ecpu_pkg::K_DEY, ecpu_pkg::K_LDY, ecpu_pkg::K_TAY: begin
            case (alu_in.kind)
               ecpu_pkg::K_INY: r = alu_in.regs.y + 8'd1;
               ecpu_pkg::K_DEY: r = alu_in.regs.y - 8'd1;
               ecpu_pkg::K_TAY: r = a;
               default:         r = v;
            endcase
            alu_out.regs.y = r;
            alu_out.regs.p[ecpu_pkg::P_Z] = (r == 8'd0);
            alu_out.regs.p[ecpu_pkg::P_N] = r[7];
         end
         ecpu_pkg::K_CMP, ecpu_pkg::K_CPX, ecpu_pkg::K_CPY: begin
            alu_out.regs.p[ecpu_pkg::P_Z] = (cmp_d == 8'd0);
            alu_out.regs.p[ecpu_pkg::P_N] = cmp_d[7];
            alu_out.regs.p[ecpu_pkg::P_C] = (cmp_r >= v);
         end
         ecpu_pkg::K_BIT: begin
            alu_out.regs.p[ecpu_pkg::P_Z] = ((a & v) == 8'd0);
            alu_out.regs.p[ecpu_pkg::P_V] = v[6];
            alu_out.regs.p[ecpu_pkg::P_N] = v[7];
         end
         ecpu_pkg::K_BCC, ecpu_pkg::K_BCS, ecpu_pkg::K_BEQ, ecpu_pkg::K_BNE,
         ecpu_pkg::K_BMI, ecpu_pkg::K_BPL, ecpu_pkg::K_BVS, ecpu_pkg::K_BVC: begin
            case (alu_in.kind)
               ecpu_pkg::K_BCC: r[0] = ~p[ecpu_pkg::P_C];
               ecpu_pkg::K_BCS: r[0] = p[ecpu_pkg::P_C];
               ecpu_pkg::K_BEQ: r[0] = p[ecpu_pkg::P_Z];
               ecpu_pkg::K_BNE: r[0] = ~p[ecpu_pkg::P_Z];
               ecpu_pkg::K_BMI: r[0] = p[ecpu_pkg::P_N];
               ecpu_pkg::K_BPL: r[0] = ~p[ecpu_pkg::P_N];
               ecpu_pkg::K_BVS: r[0] = p[ecpu_pkg::P_V];
               default:         r[0] = ~p[ecpu_pkg::P_V];
            endcase
            if (r[0]) begin
               alu_out.regs.pc = alu_in.regs.pc + {{8{v[7]}}, v};
            end
         end
         ecpu_pkg::K_CLC: alu_out.regs.p[ecpu_pkg::P_C] = 1'b0;
         ecpu_pkg::K_CLD: alu_out.regs.p[ecpu_pkg::P_D] = 1'b0;
         ecpu_pkg::K_CLI: alu_out.regs.p[ecpu_pkg::P_I] = 1'b0;
         ecpu_pkg::K_CLV: alu_out.regs.p[ecpu_pkg::P_V] = 1'b0;
         ecpu_pkg::K_SEC: alu_out.regs.p[ecpu_pkg::P_C] = 1'b1;
         ecpu_pkg::K_SED: alu_out.regs.p[ecpu_pkg::P_D] = 1'b1;
         ecpu_pkg::K_SEI: alu_out.regs.p[ecpu_pkg::P_I] = 1'b1;
         ecpu_pkg::K_JMP: alu_out.regs.pc = alu_in.ea;
         ecpu_pkg::K_TXS: alu_out.regs.sp = alu_in.regs.x;
         ecpu_pkg::K_STA, ecpu_pkg::K_PHA: alu_out.wdata = a;
         ecpu_pkg::K_STX: alu_out.wdata = alu_in.regs.x;
         ecpu_pkg::K_STY: alu_out.wdata = alu_in.regs.y;
         ecpu_pkg::K_PHP: begin
            alu_out.wdata = p;
            alu_out.wdata[ecpu_pkg::P_B] = 1'b1;
         end
         default: alu_out.regs = alu_in.regs;
      endcase
   end

endmodule
